### sv/lz_flag_group_decompressor_unit_macros.svh
// Assertion shorthands used by the checker file.
`ifndef LZ_FLAG_GROUP_DECOMPRESSOR_UNIT_MACROS_SVH
`define LZ_FLAG_GROUP_DECOMPRESSOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LZFG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lzfg same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LZFG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lzfg next-cycle check failed");

`endif

### sv/lzfg_pkg.sv
package lzfg_pkg;

  // History window
  localparam int WINDOW_DEPTH = 4096;
  localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int BYTE_W       = 8;

  // Result packing
  localparam int OUT_LANES = 8;
  localparam int LANE_IW   = $clog2(OUT_LANES);
  localparam int COUNT_W   = 4;

  // Stream format
  localparam logic [7:0] LIT_FLAG_MASK = 8'h80;
  localparam logic [3:0] NIBBLE_MASK   = 4'hF;
  localparam logic [3:0] GROUP_FLAGS   = 4'd8;
  localparam logic [8:0] SHORT_BIAS    = 9'd2;
  localparam logic [8:0] LONG_BIAS     = 9'h12;
  localparam int         LEN_W         = 9;

  // Configuration map
  localparam int          CFG_AW          = 3;
  localparam logic        REG_DECOMP_SIZE = 1'b0;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RD    = 4'b0010,
    ST_WR    = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  // Parser phase
  typedef enum logic [2:0] {
    PH_CODE = 3'd0,
    PH_LIT  = 3'd1,
    PH_REF1 = 3'd2,
    PH_REF2 = 3'd3,
    PH_REF3 = 3'd4
  } phase_t;

endpackage

### sv/lzfg_ifs.sv
// Compressed byte channel
interface lzfg_in_if;
  logic                         valid;
  logic                         ready;
  logic [lzfg_pkg::BYTE_W-1:0]  data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// Packed result channel
interface lzfg_out_if;
  logic                         valid;
  logic                         ready;
  logic [lzfg_pkg::BYTE_W-1:0]  out_byte_0;
  logic [lzfg_pkg::BYTE_W-1:0]  out_byte_1;
  logic [lzfg_pkg::BYTE_W-1:0]  out_byte_2;
  logic [lzfg_pkg::BYTE_W-1:0]  out_byte_3;
  logic [lzfg_pkg::BYTE_W-1:0]  out_byte_4;
  logic [lzfg_pkg::BYTE_W-1:0]  out_byte_5;
  logic [lzfg_pkg::BYTE_W-1:0]  out_byte_6;
  logic [lzfg_pkg::BYTE_W-1:0]  out_byte_7;
  logic [lzfg_pkg::COUNT_W-1:0] byte_count;
  logic                         run_last;
  logic                         stream_done;

  modport source (output valid, output out_byte_0, output out_byte_1, output out_byte_2,
                  output out_byte_3, output out_byte_4, output out_byte_5,
                  output out_byte_6, output out_byte_7, output byte_count,
                  output run_last, output stream_done, input ready);
  modport sink   (input valid, input out_byte_0, input out_byte_1, input out_byte_2,
                  input out_byte_3, input out_byte_4, input out_byte_5,
                  input out_byte_6, input out_byte_7, input byte_count,
                  input run_last, input stream_done, output ready);
endinterface

### sv/lz_flag_group_decompressor_unit.sv
// Sequencing: a code byte or a reference header byte is taken in ST_IDLE; a literal is
// accepted, then loaded into the result in ST_FLUSH. A copy run passes ST_RD and ST_WR
// for each byte (one window read and one write-back on the single RAM port pair), plus
// one result load in ST_FLUSH per group of up to eight bytes; no input is taken meanwhile.
// Reset (sync, active low) clears parser, counters and output valid. The window is not
// swept: entries beyond the byte count written so far read as zero.
module lz_flag_group_decompressor_unit import lzfg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  lzfg_in_if.sink           in_ch,
  lzfg_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  state_t                 state_r, state_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [7:0]             flag_bits_r, flag_bits_nxt;
  logic [3:0]             flags_left_r, flags_left_nxt;
  logic [7:0]             first_ref_r, first_ref_nxt;
  logic [WIN_AW-1:0]      ref_dist_r, ref_dist_nxt;
  logic [31:0]            bw_r, bw_nxt;
  logic [31:0]            size_r;
  logic [WIN_AW-1:0]      src_r, src_nxt;
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic                   rd_valid_r, rd_valid_nxt;
  logic                   flush_last_r, flush_last_nxt;
  logic [BYTE_W-1:0]      lanes_r [OUT_LANES];
  logic [BYTE_W-1:0]      lanes_nxt [OUT_LANES];
  logic [COUNT_W-1:0]     fill_r, fill_nxt;
  logic [BYTE_W-1:0]      obytes_r [OUT_LANES];
  logic [BYTE_W-1:0]      obytes_nxt [OUT_LANES];
  logic [COUNT_W-1:0]     ocount_r, ocount_nxt;
  logic                   olast_r, olast_nxt;
  logic                   odone_r, odone_nxt;
  logic                   ovalid_r, ovalid_nxt;

  // Window RAM port signals
  logic                   ram_we;
  logic [BYTE_W-1:0]      ram_wdata;
  logic                   ram_re;
  logic [BYTE_W-1:0]      ram_rdata;

  logic                   in_fire;
  logic                   out_free;
  logic                   cfg_wr;
  logic [7:0]             din;
  logic [WIN_AW-1:0]      new_dist;
  logic [BYTE_W-1:0]      copy_byte;
  logic [COUNT_W-1:0]     fill_inc;
  logic                   run_end;

  // Flag advance after a literal or a copy
  logic [7:0]             nf_bits;
  logic [3:0]             nf_left;
  phase_t                 nf_phase;

  assign din      = in_ch.data_byte;
  assign in_fire  = in_ch.valid && (state_r == ST_IDLE);
  assign out_free = !ovalid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  assign nf_bits  = {flag_bits_r[6:0], 1'b0};
  assign nf_left  = (flags_left_r != 4'd0) ? 4'(flags_left_r - 4'd1) : 4'd0;
  assign nf_phase = (nf_left == 4'd0) ? PH_CODE :
                    (((nf_bits & LIT_FLAG_MASK) != 8'd0) ? PH_LIT : PH_REF1);

  assign new_dist  = {first_ref_r[3:0] & NIBBLE_MASK, din};
  assign copy_byte = rd_valid_r ? ram_rdata : '0;
  assign fill_inc  = COUNT_W'(fill_r + COUNT_W'(1));
  assign run_end   = (len_r == LEN_W'(1)) || ((bw_r + 32'd1) >= size_r);

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_DECOMP_SIZE) ? size_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 32'd0;
    end else if (cfg_wr && (paddr[2] == REG_DECOMP_SIZE)) begin
      size_r <= pwdata;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    flag_bits_nxt  = flag_bits_r;
    flags_left_nxt = flags_left_r;
    first_ref_nxt  = first_ref_r;
    ref_dist_nxt   = ref_dist_r;
    bw_nxt         = bw_r;
    src_nxt        = src_r;
    len_nxt        = len_r;
    rd_valid_nxt   = rd_valid_r;
    flush_last_nxt = flush_last_r;
    lanes_nxt      = lanes_r;
    fill_nxt       = fill_r;
    obytes_nxt     = obytes_r;
    ocount_nxt     = ocount_r;
    olast_nxt      = olast_r;
    odone_nxt      = odone_r;
    ovalid_nxt     = ovalid_r && !out_ch.ready;
    ram_we         = 1'b0;
    ram_wdata      = din;
    ram_re         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (bw_r < size_r)) begin
          case (phase_r)
            PH_LIT: begin
              lanes_nxt[0]   = din;
              fill_nxt       = COUNT_W'(1);
              ram_we         = 1'b1;
              bw_nxt         = bw_r + 32'd1;
              flag_bits_nxt  = nf_bits;
              flags_left_nxt = nf_left;
              phase_nxt      = nf_phase;
              flush_last_nxt = 1'b1;
              state_nxt      = ST_FLUSH;
            end
            PH_REF1: begin
              first_ref_nxt = din;
              phase_nxt     = PH_REF2;
            end
            PH_REF2: begin
              ref_dist_nxt = new_dist;
              if (first_ref_r[7:4] != 4'd0) begin
                len_nxt        = LEN_W'({5'd0, first_ref_r[7:4]}) + SHORT_BIAS;
                src_nxt        = WIN_AW'(bw_r[WIN_AW-1:0] - new_dist - WIN_AW'(1));
                flag_bits_nxt  = nf_bits;
                flags_left_nxt = nf_left;
                phase_nxt      = nf_phase;
                state_nxt      = ST_RD;
              end else begin
                phase_nxt = PH_REF3;
              end
            end
            PH_REF3: begin
              len_nxt        = LEN_W'({1'b0, din}) + LONG_BIAS;
              src_nxt        = WIN_AW'(bw_r[WIN_AW-1:0] - ref_dist_r - WIN_AW'(1));
              flag_bits_nxt  = nf_bits;
              flags_left_nxt = nf_left;
              phase_nxt      = nf_phase;
              state_nxt      = ST_RD;
            end
            default: begin
              // code byte, also any unused phase code
              flag_bits_nxt  = din;
              flags_left_nxt = GROUP_FLAGS;
              phase_nxt      = ((din & LIT_FLAG_MASK) != 8'd0) ? PH_LIT : PH_REF1;
            end
          endcase
        end
      end

      ST_RD: begin
        // entries past the write count were never written: read as zero
        ram_re       = 1'b1;
        rd_valid_nxt = (bw_r[31:WIN_AW] != '0) || (src_r < bw_r[WIN_AW-1:0]);
        state_nxt    = ST_WR;
      end

      ST_WR: begin
        lanes_nxt[fill_r[LANE_IW-1:0]] = copy_byte;
        fill_nxt  = fill_inc;
        ram_we    = 1'b1;
        ram_wdata = copy_byte;
        bw_nxt    = bw_r + 32'd1;
        len_nxt   = LEN_W'(len_r - LEN_W'(1));
        src_nxt   = WIN_AW'(src_r + WIN_AW'(1));
        if (run_end || (fill_inc == COUNT_W'(OUT_LANES))) begin
          flush_last_nxt = run_end;
          state_nxt      = ST_FLUSH;
        end else begin
          state_nxt = ST_RD;
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          obytes_nxt = lanes_r;
          ocount_nxt = fill_r;
          olast_nxt  = flush_last_r;
          odone_nxt  = (bw_r >= size_r);
          ovalid_nxt = 1'b1;
          for (int i = 0; i < OUT_LANES; i++) begin
            lanes_nxt[i] = '0;
          end
          fill_nxt  = '0;
          state_nxt = flush_last_r ? ST_IDLE : ST_RD;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= PH_CODE;
      flag_bits_r  <= '0;
      flags_left_r <= '0;
      first_ref_r  <= '0;
      ref_dist_r   <= '0;
      bw_r         <= '0;
      fill_r       <= '0;
      flush_last_r <= 1'b0;
      ovalid_r     <= 1'b0;
      for (int i = 0; i < OUT_LANES; i++) begin
        lanes_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      flag_bits_r  <= flag_bits_nxt;
      flags_left_r <= flags_left_nxt;
      first_ref_r  <= first_ref_nxt;
      ref_dist_r   <= ref_dist_nxt;
      bw_r         <= bw_nxt;
      fill_r       <= fill_nxt;
      flush_last_r <= flush_last_nxt;
      ovalid_r     <= ovalid_nxt;
      lanes_r      <= lanes_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    len_r      <= len_nxt;
    rd_valid_r <= rd_valid_nxt;
    obytes_r   <= obytes_nxt;
    ocount_r   <= ocount_nxt;
    olast_r    <= olast_nxt;
    odone_r    <= odone_nxt;
  end

  // History window
  lzfg_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (bw_r[WIN_AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (src_r),
    .rdata (ram_rdata)
  );

  // Result beat
  assign out_ch.valid       = ovalid_r;
  assign out_ch.out_byte_0  = obytes_r[0];
  assign out_ch.out_byte_1  = obytes_r[1];
  assign out_ch.out_byte_2  = obytes_r[2];
  assign out_ch.out_byte_3  = obytes_r[3];
  assign out_ch.out_byte_4  = obytes_r[4];
  assign out_ch.out_byte_5  = obytes_r[5];
  assign out_ch.out_byte_6  = obytes_r[6];
  assign out_ch.out_byte_7  = obytes_r[7];
  assign out_ch.byte_count  = ocount_r;
  assign out_ch.run_last    = olast_r;
  assign out_ch.stream_done = odone_r;

endmodule

### sv/lzfg_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
module lzfg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/lzfg_chk.sv
`include "lz_flag_group_decompressor_unit_macros.svh"

// Port-level checks on the result channel.
module lzfg_chk import lzfg_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [BYTE_W-1:0]  out_byte_1,
  input logic [BYTE_W-1:0]  out_byte_7,
  input logic [COUNT_W-1:0] byte_count,
  input logic               run_last,
  input logic               stream_done
);

  // a beat carries one to eight bytes
  `LZFG_ASSERT_NOW(a_count_range, out_valid,
    (byte_count != '0) && (byte_count <= COUNT_W'(OUT_LANES)))

  // lanes past the count read zero
  `LZFG_ASSERT_NOW(a_lane1_zero, out_valid && (byte_count == COUNT_W'(1)),
    out_byte_1 == '0)
  `LZFG_ASSERT_NOW(a_lane7_zero, out_valid && (byte_count != COUNT_W'(OUT_LANES)),
    out_byte_7 == '0)

  // reaching the size always closes the run
  `LZFG_ASSERT_NOW(a_done_last, out_valid && stream_done, run_last)

  // stalled beat holds
  `LZFG_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
    out_valid && $stable(byte_count) && $stable(run_last) && $stable(out_byte_7))

endmodule

bind lz_flag_group_decompressor_unit lzfg_chk u_lzfg_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte_1  (out_ch.out_byte_1),
  .out_byte_7  (out_ch.out_byte_7),
  .byte_count  (out_ch.byte_count),
  .run_last    (out_ch.run_last),
  .stream_done (out_ch.stream_done)
);
